### src/itp_pkg.sv
package itp_pkg;

    localparam int CHAR_W          = 8;
    localparam int DEF_STACK_DEPTH = 16;

    localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;

    typedef logic signed [2:0] t_rank;

    localparam t_rank RANK_PAREN = 3'sd3;
    localparam t_rank RANK_ADD   = 3'sd2;
    localparam t_rank RANK_MUL   = 3'sd1;
    localparam t_rank RANK_OPEN  = 3'sd0;
    localparam t_rank RANK_OTHER = -3'sd1;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              run_last;
        logic              expr_done;
        logic              stack_overflow;
    } t_result;

    function automatic t_rank stack_rank(input logic [CHAR_W-1:0] c);
        t_rank r;
        case (c)
            CHAR_LPAREN:            r = RANK_PAREN;
            CHAR_PLUS, CHAR_MINUS:  r = RANK_ADD;
            CHAR_STAR, CHAR_SLASH:  r = RANK_MUL;
            default:                r = RANK_OTHER;
        endcase
        return r;
    endfunction

    function automatic t_rank token_rank(input logic [CHAR_W-1:0] c);
        t_rank r;
        if (c == CHAR_LPAREN) begin
            r = RANK_OPEN;
        end else begin
            r = stack_rank(c);
        end
        return r;
    endfunction

    function automatic logic is_num(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) || (c == CHAR_DOT);
    endfunction

endpackage

### src/itp_ram.sv
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/itp_out.sv
module itp_out import itp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### src/itp_seq.sv
module itp_seq import itp_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [CHAR_W-1:0]              i_char,
    input  logic                           i_last,
    output logic                           o_ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0] o_ram_waddr,
    output logic [CHAR_W-1:0]              o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(STACK_DEPTH)-1:0] o_ram_raddr,
    input  logic [CHAR_W-1:0]              i_ram_rdata,
    input  logic                           i_free,
    output logic                           o_push,
    output t_result                        o_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_SPACE, S_POP, S_RD, S_FIN} t_state;
    typedef enum logic [1:0] {M_CLOSE, M_OPER, M_FLUSH} t_mode;

    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic [CW-1:0]     r_count, n_count;
    logic              r_in_number, n_in_number;
    logic [CHAR_W-1:0] r_top, n_top;
    logic [CHAR_W-1:0] r_c, n_c;
    logic              r_last, n_last;
    logic              r_ovf, n_ovf;
    logic              r_hit, n_hit;
    logic              r_pend_v, n_pend_v;
    logic [CHAR_W-1:0] r_pend_ch, n_pend_ch;
    logic              r_pend_cv, n_pend_cv;

    logic              gen;
    logic [CHAR_W-1:0] gen_ch;
    logic              can_go;
    logic              do_pop;
    logic              do_emit;
    logic              top_open;
    logic [CW-1:0]     count_dec;
    logic [CW-1:0]     rd_idx;

    assign can_go    = !r_pend_v || i_free;
    assign top_open  = (r_top == CHAR_LPAREN);
    assign count_dec = r_count - CW'(1);
    assign rd_idx    = r_count - CW'(2);
    assign o_stall   = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_in_number = r_in_number;
        n_top       = r_top;
        n_c         = r_c;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_hit       = r_hit;
        n_pend_v    = r_pend_v;
        n_pend_ch   = r_pend_ch;
        n_pend_cv   = r_pend_cv;
        gen         = 1'b0;
        gen_ch      = CHAR_SPACE;
        do_pop      = 1'b0;
        do_emit     = !top_open;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = r_c;
        o_ram_re    = 1'b0;
        o_ram_raddr = rd_idx[AW-1:0];
        o_push      = 1'b0;
        o_res       = '{out_char: r_pend_ch, char_valid: r_pend_cv, run_last: 1'b0,
                        expr_done: 1'b0, stack_overflow: r_ovf};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_c    = i_char;
                    n_last = i_last;
                    n_hit  = 1'b0;
                    if (is_num(i_char)) begin
                        gen         = 1'b1;
                        gen_ch      = i_char;
                        n_in_number = 1'b1;
                        n_ovf       = 1'b0;
                        n_state     = i_last ? S_SPACE : S_FIN;
                    end else begin
                        if (r_in_number) begin
                            gen         = 1'b1;
                            gen_ch      = CHAR_SPACE;
                            n_in_number = 1'b0;
                        end
                        if (i_char == CHAR_RPAREN) begin
                            n_mode = M_CLOSE;
                            n_ovf  = 1'b0;
                        end else begin
                            n_mode = M_OPER;
                            n_ovf  = (r_count == CW'(STACK_DEPTH)) &&
                                     (stack_rank(r_top) > token_rank(i_char));
                        end
                        n_state = S_POP;
                    end
                end
            end
            S_SPACE: begin
                if (can_go) begin
                    gen         = 1'b1;
                    gen_ch      = CHAR_SPACE;
                    n_in_number = 1'b0;
                    n_mode      = M_FLUSH;
                    n_state     = S_POP;
                end
            end
            S_POP: begin
                case (r_mode)
                    M_CLOSE: begin
                        do_pop  = (r_count != '0) && !r_hit;
                    end
                    M_OPER: begin
                        do_pop  = (r_count != '0) &&
                                  !(stack_rank(r_top) > token_rank(r_c));
                    end
                    M_FLUSH: begin
                        do_pop  = (r_count != '0);
                    end
                    default: begin
                        do_pop  = 1'b0;
                    end
                endcase
                if (do_pop) begin
                    if (!do_emit || can_go) begin
                        gen     = do_emit;
                        gen_ch  = r_top;
                        n_count = count_dec;
                        if ((r_mode == M_CLOSE) && top_open) begin
                            n_hit = 1'b1;
                        end
                        if (count_dec != '0) begin
                            o_ram_re = 1'b1;
                            n_state  = S_RD;
                        end
                    end
                end else begin
                    if ((r_mode == M_OPER) && (r_count < CW'(STACK_DEPTH))) begin
                        o_ram_we = 1'b1;
                        n_top    = r_c;
                        n_count  = r_count + CW'(1);
                    end
                    if ((r_mode != M_FLUSH) && r_last) begin
                        n_mode = M_FLUSH;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD: begin
                n_top   = i_ram_rdata;
                n_state = S_POP;
            end
            S_FIN: begin
                if (r_pend_v || r_last || r_ovf) begin
                    if (i_free) begin
                        o_push   = 1'b1;
                        o_res    = '{out_char: r_pend_v ? r_pend_ch : CHAR_NUL,
                                     char_valid: r_pend_v && r_pend_cv,
                                     run_last: 1'b1, expr_done: r_last,
                                     stack_overflow: r_ovf};
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (gen) begin
            if (r_pend_v) begin
                o_push = 1'b1;
            end
            n_pend_v  = 1'b1;
            n_pend_ch = gen_ch;
            n_pend_cv = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_in_number <= 1'b0;
            r_pend_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_in_number <= n_in_number;
            r_pend_v    <= n_pend_v;
        end
        r_mode    <= n_mode;
        r_top     <= n_top;
        r_c       <= n_c;
        r_last    <= n_last;
        r_ovf     <= n_ovf;
        r_hit     <= n_hit;
        r_pend_ch <= n_pend_ch;
        r_pend_cv <= n_pend_cv;
    end

endmodule

### src/infix_to_postfix_converter_top.sv
// Flow: a digit passes through the pending character register and then the output register;
// an operator pops the stack (each pop followed by the RAM read that refills the top) and is
// then pushed. Pops use the single RAM read port and wait while the output cannot take the
// popped character; one transaction in flight at a time (o_stall until the sequencer is idle).
// Reset: synchronous, active low; clears stack count, number flag and output valid.
// The stack RAM is not cleared.
module infix_to_postfix_converter_top import itp_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_in_char,
    input  logic              i_expr_last,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_char_valid,
    output logic              o_run_last,
    output logic              o_expr_done,
    output logic              o_stack_overflow
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;
    logic              out_free;
    logic              out_push;
    t_result           seq_res;
    t_result           out_res;

    itp_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    itp_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char      (i_in_char),
        .i_last      (i_expr_last),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .i_free      (out_free),
        .o_push      (out_push),
        .o_res       (seq_res)
    );

    itp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_res   (seq_res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_out_char       = out_res.out_char;
    assign o_char_valid     = out_res.char_valid;
    assign o_run_last       = out_res.run_last;
    assign o_expr_done      = out_res.expr_done;
    assign o_stack_overflow = out_res.stack_overflow;

endmodule
